[rtl/mie_pkg.sv]
// shared types, instruction codes and constants of the mips instruction executor
package mie_pkg;

  localparam int MEM_WORDS_DEF = 4096;

  // item classes as sorted by the front end
  typedef enum logic [2:0] {
    K_EXEC,
    K_LOAD,
    K_SET_GPR,
    K_SET_HI,
    K_SET_LO,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] value;
    logic [4:0]  reg_index;
  } item_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        mem_written;
    logic [31:0] store_address;
    logic [31:0] store_word;
    logic        halted;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_MEM,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  // item modes
  localparam logic [2:0] MODE_EXEC    = 3'd0;
  localparam logic [2:0] MODE_LOAD    = 3'd1;
  localparam logic [2:0] MODE_SET_GPR = 3'd2;
  localparam logic [2:0] MODE_SET_HI  = 3'd3;
  localparam logic [2:0] MODE_SET_LO  = 3'd4;

  // configuration register indexes
  localparam logic CFG_MEM_BASE = 1'b0;
  localparam logic CFG_START_PC = 1'b1;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  localparam logic [4:0]  REG_V0      = 5'd2;
  localparam logic [4:0]  REG_LINK    = 5'd31;
  localparam logic [31:0] SYSCALL_HALT = 32'h0000_000A;

endpackage

[rtl/mie_front.sv]
// front end: two-entry item queue that sorts items by mode
module mie_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            hold,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      mode,
  input  logic [31:0]     address,
  input  logic [31:0]     value,
  input  logic [4:0]      reg_index,
  output logic            item_valid,
  output mie_pkg::item_t  item,
  input  logic            item_take
);
  import mie_pkg::*;

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       wr_ok;
  kind_t      kind;

  always_comb begin
    case (mode)
      MODE_EXEC:    kind = K_EXEC;
      MODE_LOAD:    kind = K_LOAD;
      MODE_SET_GPR: kind = K_SET_GPR;
      MODE_SET_HI:  kind = K_SET_HI;
      MODE_SET_LO:  kind = K_SET_LO;
      default:      kind = K_NONE;
    endcase
  end

  assign full       = (cnt == 2'd2) || hold;
  assign wr_ok      = push && !full;
  assign item_valid = (cnt != 2'd0);
  assign item       = slots[rp];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slots[wp] <= '{kind: kind, address: address, value: value, reg_index: reg_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_ok) wp <= ~wp;
      if (item_take) rp <= ~rp;
      cnt <= cnt + {1'b0, wr_ok} - {1'b0, item_take};
    end
  end

endmodule

[rtl/mie_div.sv]
// unsigned restoring divider, one quotient bit per cycle
module mie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  import mie_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] d;
  logic [32:0] rsh;
  logic [32:0] diff;

  assign rsh  = {rem, quot[31]};
  assign diff = rsh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      d    <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= rsh[31:0];
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/mie_back.sv]
// back end: sequencer, register file, word memory, multiplier and result register
module mie_back #(
  parameter int MEM_WORDS = mie_pkg::MEM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  input  mie_pkg::item_t    item,
  output logic              item_take,
  output logic              clearing,
  input  logic              pop,
  output logic              empty,
  output mie_pkg::result_t  res
);
  import mie_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

  state_t state, state_next;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_rd;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;
  logic [AW-1:0] clr_cnt;

  logic [31:0] gpr [32];
  logic [31:0] gv;
  logic [31:0] ga, gb;
  logic        va, vb;
  logic [4:0]  ra_a, ra_b;

  logic [31:0] pc, base, hi, lo;
  logic        stopped;
  logic [31:0] ins, npc_r, ea_r;
  logic        ea_win_r;
  logic [63:0] prod;
  logic        sgn_q, sgn_r;

  result_t res_q;
  logic    out_valid;
  result_t out_res;
  logic    out_load;

  // finish strobes
  logic        fin;
  logic        f_wr_en;
  logic [4:0]  f_wr_idx;
  logic [31:0] f_wr_val;
  logic [31:0] f_pc, f_hi, f_lo;
  logic        f_stop;
  logic        f_mw;
  logic [31:0] f_sa, f_sw;

  // decode fields
  logic [31:0] ins_w, a, b;
  logic [5:0]  op, funct;
  logic [4:0]  rt, rd, sh;
  logic [31:0] imm, simm, npc, btgt, ea, jt, npc_calc;
  logic [29:0] pc_off, ea_off, it_off;
  logic        pc_win, ea_win, it_win;
  logic        mul_signed, div_signed, div_start, div_done;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [31:0] div_n, div_d, div_q, div_r;
  logic [31:0] wmem, merged;
  logic [7:0]  lb;
  logic [15:0] lh;

  assign pc_off = pc[31:2] - base[31:2];
  assign ea_off = ea[31:2] - base[31:2];
  assign it_off = item.address[31:2] - base[31:2];
  assign pc_win = pc_off < 30'(MEM_WORDS);
  assign ea_win = ea_off < 30'(MEM_WORDS);
  assign it_win = it_off < 30'(MEM_WORDS);

  // fetched word and register read addresses
  assign ins_w = pc_win ? mem_rd : 32'd0;
  assign ra_a  = (ins_w[31:26] == OP_SPECIAL && ins_w[5:0] == FN_SYSCALL) ? REG_V0
                                                                         : ins_w[25:21];
  assign ra_b  = ins_w[20:16];

  assign a     = va ? ga : 32'd0;
  assign b     = vb ? gb : 32'd0;
  assign op    = ins[31:26];
  assign funct = ins[5:0];
  assign rt    = ins[20:16];
  assign rd    = ins[15:11];
  assign sh    = ins[10:6];
  assign imm   = {16'd0, ins[15:0]};
  assign simm  = {{16{ins[15]}}, ins[15:0]};
  assign npc   = pc + 32'd4;
  assign btgt  = npc + {simm[29:0], 2'b00};
  assign ea    = a + simm;
  assign jt    = {npc[31:28], ins[25:0], 2'b00};

  assign mul_signed = (funct == FN_MULT);
  assign div_signed = (funct == FN_DIV);
  assign ma = {mul_signed & a[31], a};
  assign mb = {mul_signed & b[31], b};
  assign mp = ma * mb;
  assign div_n = (div_signed && a[31]) ? 32'd0 - a : a;
  assign div_d = (div_signed && b[31]) ? 32'd0 - b : b;

  assign wmem = ea_win_r ? mem_rd : 32'd0;
  assign lb   = wmem[{ea_r[1:0], 3'b000} +: 8];
  assign lh   = ea_r[1] ? wmem[31:16] : wmem[15:0];

  always_comb begin
    merged = b;
    case (op)
      OP_SB: begin
        merged = wmem;
        merged[{ea_r[1:0], 3'b000} +: 8] = b[7:0];
      end
      OP_SH: begin
        merged = wmem;
        merged[{ea_r[1], 4'b0000} +: 16] = b[15:0];
      end
      default: merged = b;
    endcase
  end

  mie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    state_next = state;
    item_take  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = clr_cnt;
    mem_wd     = 32'd0;
    mem_ra     = pc_off[AW-1:0];
    div_start  = 1'b0;
    out_load   = 1'b0;
    fin        = 1'b0;
    f_wr_en    = 1'b0;
    f_wr_idx   = 5'd0;
    f_wr_val   = 32'd0;
    f_pc       = pc;
    f_hi       = hi;
    f_lo       = lo;
    f_stop     = stopped;
    f_mw       = 1'b0;
    f_sa       = 32'd0;
    f_sw       = 32'd0;
    npc_calc   = npc;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == LAST_WORD) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          case (item.kind)
            K_EXEC: begin
              if (stopped) fin = 1'b1;
              else state_next = S_FETCH;
            end
            K_LOAD: begin
              fin = 1'b1;
              if (it_win) begin
                mem_we = 1'b1;
                mem_wa = it_off[AW-1:0];
                mem_wd = item.value;
                f_mw   = 1'b1;
                f_sa   = {item.address[31:2], 2'b00};
                f_sw   = item.value;
              end
            end
            K_SET_GPR: begin
              fin      = 1'b1;
              f_wr_idx = item.reg_index;
              f_wr_val = item.value;
            end
            K_SET_HI: begin
              fin  = 1'b1;
              f_hi = item.value;
            end
            K_SET_LO: begin
              fin  = 1'b1;
              f_lo = item.value;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        mem_ra = ea_off[AW-1:0];
        fin    = 1'b1;
        if (op == OP_SPECIAL) begin
          case (funct)
            FN_ADD, FN_ADDU: begin f_wr_idx = rd; f_wr_val = a + b; end
            FN_SUB, FN_SUBU: begin f_wr_idx = rd; f_wr_val = a - b; end
            FN_AND: begin f_wr_idx = rd; f_wr_val = a & b; end
            FN_OR:  begin f_wr_idx = rd; f_wr_val = a | b; end
            FN_XOR: begin f_wr_idx = rd; f_wr_val = a ^ b; end
            FN_NOR: begin f_wr_idx = rd; f_wr_val = ~(a | b); end
            FN_SLT: begin
              f_wr_idx = rd;
              f_wr_val = {31'd0, $signed(a) < $signed(b)};
            end
            FN_SLL: begin f_wr_idx = rd; f_wr_val = b << sh; end
            FN_SRL: begin f_wr_idx = rd; f_wr_val = b >> sh; end
            FN_SRA: begin f_wr_idx = rd; f_wr_val = $unsigned($signed(b) >>> sh); end
            FN_JR:  npc_calc = a;
            FN_JALR: begin
              f_wr_idx = rd;
              f_wr_val = pc + 32'd8;
              npc_calc = a;
            end
            FN_MFHI: begin f_wr_idx = rd; f_wr_val = hi; end
            FN_MFLO: begin f_wr_idx = rd; f_wr_val = lo; end
            FN_MTHI: f_hi = a;
            FN_MTLO: f_lo = a;
            FN_MULT, FN_MULTU: begin
              fin        = 1'b0;
              state_next = S_MUL;
            end
            FN_DIV, FN_DIVU: begin
              if (b != 32'd0) begin
                fin        = 1'b0;
                div_start  = 1'b1;
                state_next = S_DIV;
              end
            end
            FN_SYSCALL: begin
              if (a == SYSCALL_HALT) f_stop = 1'b1;
            end
            default: ;
          endcase
        end else begin
          case (op)
            OP_J: npc_calc = jt;
            OP_JAL: begin
              npc_calc = jt;
              f_wr_idx = REG_LINK;
              f_wr_val = pc + 32'd8;
            end
            OP_BEQ:  if (a == b) npc_calc = btgt;
            OP_BNE:  if (a != b) npc_calc = btgt;
            OP_BLEZ: if (a == 32'd0 || a[31]) npc_calc = btgt;
            OP_BGTZ: if (a != 32'd0 && !a[31]) npc_calc = btgt;
            OP_REGIMM: begin
              if (rt == RT_BLTZ && a[31]) npc_calc = btgt;
              else if (rt == RT_BGEZ && !a[31]) npc_calc = btgt;
            end
            OP_ADDI, OP_ADDIU: begin f_wr_idx = rt; f_wr_val = a + simm; end
            OP_SLTI: begin
              f_wr_idx = rt;
              f_wr_val = {31'd0, $signed(a) < $signed(simm)};
            end
            OP_ANDI: begin f_wr_idx = rt; f_wr_val = a & imm; end
            OP_ORI:  begin f_wr_idx = rt; f_wr_val = a | imm; end
            OP_XORI: begin f_wr_idx = rt; f_wr_val = a ^ imm; end
            OP_LUI:  begin f_wr_idx = rt; f_wr_val = {ins[15:0], 16'd0}; end
            OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW: begin
              fin        = 1'b0;
              state_next = S_MEM;
            end
            default: ;
          endcase
        end
        f_pc = npc_calc;
      end
      S_MEM: begin
        fin  = 1'b1;
        f_pc = npc_r;
        case (op)
          OP_LB: begin f_wr_idx = rt; f_wr_val = {{24{lb[7]}}, lb}; end
          OP_LH: begin f_wr_idx = rt; f_wr_val = {{16{lh[15]}}, lh}; end
          OP_LW: begin f_wr_idx = rt; f_wr_val = wmem; end
          default: begin
            if (ea_win_r) begin
              mem_we = 1'b1;
              mem_wa = ea_r[AW+1:2] - base[AW+1:2];
              mem_wd = merged;
              f_mw   = 1'b1;
              f_sa   = {ea_r[31:2], 2'b00};
              f_sw   = merged;
            end
          end
        endcase
      end
      S_MUL: begin
        fin  = 1'b1;
        f_pc = npc_r;
        f_hi = prod[63:32];
        f_lo = prod[31:0];
      end
      S_DIV: begin
        f_pc = npc_r;
        if (div_done) begin
          fin  = 1'b1;
          f_lo = sgn_q ? 32'd0 - div_q : div_q;
          f_hi = sgn_r ? 32'd0 - div_r : div_r;
        end
      end
      S_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    f_wr_en = (f_wr_idx != 5'd0);
    if (!f_wr_en) f_wr_val = 32'd0;
    if (fin) state_next = S_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // word memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  // register file with registered reads
  always_ff @(posedge clk) begin
    if (fin && f_wr_en) gpr[f_wr_idx] <= f_wr_val;
    if (state == S_FETCH) begin
      ga <= gpr[ra_a];
      gb <= gpr[ra_b];
      va <= gv[ra_a];
      vb <= gv[ra_b];
      ins <= ins_w;
    end
    if (state == S_EXEC) begin
      npc_r    <= npc_calc;
      ea_r     <= ea;
      ea_win_r <= ea_win;
      prod     <= mp[63:0];
      sgn_q    <= div_signed && (a[31] ^ b[31]);
      sgn_r    <= div_signed && a[31];
    end
    if (fin) begin
      res_q <= '{pc_after: f_pc, reg_written: f_wr_en, written_index: f_wr_en ? f_wr_idx : 5'd0,
                 written_value: f_wr_val, hi_value: f_hi, lo_value: f_lo, mem_written: f_mw,
                 store_address: f_sa, store_word: f_sw, halted: f_stop};
    end
    if (out_load) out_res <= res_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      gv        <= '0;
      pc        <= 32'h0040_0000;
      base      <= 32'h0040_0000;
      hi        <= 32'd0;
      lo        <= 32'd0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (fin) begin
        if (f_wr_en) gv[f_wr_idx] <= 1'b1;
        pc      <= f_pc;
        hi      <= f_hi;
        lo      <= f_lo;
        stopped <= f_stop;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEM_BASE: base <= cfg_data;
          CFG_START_PC: pc   <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  assign clearing = (state == S_CLEAR);
  assign empty    = !out_valid;
  assign res      = out_res;

`ifndef NO_ASSERTIONS
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.reg_written) |-> (out_res.written_index == 5'd0))
    else $error("written index set without a register write");
  a_r0_never_valid: assert property (@(posedge clk) disable iff (rst) !gv[0])
    else $error("register zero was written");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !item_take)
    else $error("item taken during memory clear");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside divide wait");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register not filled after load");
`endif

endmodule

[rtl/mips_instruction_executor.sv]
// top level of the mips instruction executor
// Executes one MIPS32 integer item at a time: mode 0 fetches and runs the instruction at
// the pc from the internal word memory, modes 1 to 4 load a memory word or set a general
// register, hi or lo. Each item yields exactly one result on the output queue. After reset
// the word memory is swept to zero, one word per cycle; full stays high over that time
// while configuration writes still land. In the back end, setup items and halted execute
// items finish straight from idle; plain alu, branch and jump instructions pass through
// fetch and execute; loads, stores and multiplies add a state for the registered memory
// read or the registered 33x33 product, and divides wait on the divider, which retires
// one quotient bit per cycle. A two-entry input queue takes new items while the back
// end works, and a result register holds the finished result until it is popped.
module mips_instruction_executor #(
  parameter int MEM_WORDS = mie_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode,
  input  logic [31:0] address,
  input  logic [31:0] value,
  input  logic [4:0]  reg_index,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pc_after,
  output logic        reg_written,
  output logic [4:0]  written_index,
  output logic [31:0] written_value,
  output logic [31:0] hi_value,
  output logic [31:0] lo_value,
  output logic        mem_written,
  output logic [31:0] store_address,
  output logic [31:0] store_word,
  output logic        halted
);
  import mie_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    clearing;
  result_t res;

  // front end sorts items, holds off transfers while memory is cleared
  mie_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .address    (address),
    .value      (value),
    .reg_index  (reg_index),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // back end runs the item and owns all architectural state
  mie_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .clearing   (clearing),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  // unpack the result register onto the ports
  assign pc_after      = res.pc_after;
  assign reg_written   = res.reg_written;
  assign written_index = res.written_index;
  assign written_value = res.written_value;
  assign hi_value      = res.hi_value;
  assign lo_value      = res.lo_value;
  assign mem_written   = res.mem_written;
  assign store_address = res.store_address;
  assign store_word    = res.store_word;
  assign halted        = res.halted;

endmodule
